### src/ccc_pkg.sv
// Package for the column consensus caller: sizes, slot codes, row and control types,
// and the read-character classification table.
// No dependencies; the other files in src/ but ccc_score_ram use it by scoped names.
package ccc_pkg;

	localparam int COLUMNS    = 4096;
	localparam int SCORE_BITS = 20;

	localparam int COLUMN_W   = 12;
	localparam int CHAR_W     = 8;
	localparam int CUTOFF_W   = 7;
	localparam int CODE_W     = 3;
	localparam int WEIGHT_W   = 7;
	localparam int SLOT_COUNT = 6;

	// Columns beyond what the column field can address are never touched.
	localparam int MEM_DEPTH = (COLUMNS < (1 << COLUMN_W)) ? COLUMNS : (1 << COLUMN_W);
	localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
	localparam int ROW_W     = SLOT_COUNT * SCORE_BITS;
	localparam int PROD_W    = SCORE_BITS + CUTOFF_W;

	localparam logic [CUTOFF_W-1:0] CUTOFF_RESET  = 7'd100;
	localparam logic [CUTOFF_W-1:0] PERCENT_SCALE = 7'd100;

	localparam logic [WEIGHT_W-1:0] W_FULL = 7'd100;
	localparam logic [WEIGHT_W-1:0] W_PART = 7'd75;
	localparam logic [WEIGHT_W-1:0] W_LOW  = 7'd10;

	// Result buffer
	localparam int OUT_DEPTH = 4;
	localparam int OUT_PTR_W = 2;
	localparam int OUT_CNT_W = 3;

	typedef enum logic [CODE_W-1:0] {
		SLOT_C,
		SLOT_T,
		SLOT_A,
		SLOT_G,
		SLOT_PAD,
		SLOT_OTHER
	} slot_t;

	// Consensus codes share the slot numbering; "other" reads as no consensus.
	localparam logic [CODE_W-1:0] CODE_NONE = CODE_W'(SLOT_OTHER);

	typedef logic [SCORE_BITS-1:0] score_t;
	typedef logic [SLOT_COUNT-1:0][SCORE_BITS-1:0] row_t;

	typedef struct packed {
		logic                hit;
		slot_t               slot;
		logic [WEIGHT_W-1:0] weight;
	} char_class_t;

	// Control of the item in the modify stage.
	typedef struct packed {
		logic        valid;
		logic        is_read;
		logic        in_range;
		char_class_t cls;
	} s1_ctrl_t;

	function automatic char_class_t classify(input logic [CHAR_W-1:0] ch);
		char_class_t c;
		c = '{hit: 1'b0, slot: SLOT_C, weight: '0};
		case (ch) inside
			"C", "D", "K", "c": c = '{hit: 1'b1, slot: SLOT_C, weight: W_FULL};
			"T", "V", "L", "t": c = '{hit: 1'b1, slot: SLOT_T, weight: W_FULL};
			"A", "B", "M", "a": c = '{hit: 1'b1, slot: SLOT_A, weight: W_FULL};
			"G", "H", "N", "g": c = '{hit: 1'b1, slot: SLOT_G, weight: W_FULL};
			"1": c = '{hit: 1'b1, slot: SLOT_C, weight: W_PART};
			"2": c = '{hit: 1'b1, slot: SLOT_T, weight: W_PART};
			"3": c = '{hit: 1'b1, slot: SLOT_A, weight: W_PART};
			"4": c = '{hit: 1'b1, slot: SLOT_G, weight: W_PART};
			"R", "Y", "5", "6", "7", "8", "-": c = '{hit: 1'b1, slot: SLOT_OTHER, weight: W_LOW};
			"*", ",": c = '{hit: 1'b1, slot: SLOT_PAD, weight: W_FULL};
			default: c = '{hit: 1'b0, slot: SLOT_C, weight: '0};
		endcase
		return c;
	endfunction

endpackage

### src/ccc_score_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Read of an address written in the same cycle returns the old contents.
// No dependencies.
module ccc_score_ram #(
	parameter int DATA_W = 8,
	parameter int ADDR_W = 4,
	parameter int DEPTH  = 16
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### src/ccc_update.sv
// Modify stage: saturating score update or column clear, plus the cutoff product.
// Depends on ccc_pkg.
module ccc_update (
	input  ccc_pkg::s1_ctrl_t                ctrl,
	input  ccc_pkg::row_t                    row_in,
	input  logic [ccc_pkg::CUTOFF_W-1:0]     cutoff,
	output logic                             wr_en,
	output ccc_pkg::row_t                    wr_row,
	output logic [ccc_pkg::PROD_W-1:0]       need
);

	logic [ccc_pkg::SCORE_BITS:0]   sum_slot;
	logic [ccc_pkg::SCORE_BITS:0]   sum_other;
	logic [ccc_pkg::WEIGHT_W:0]     add_other;
	ccc_pkg::score_t                sat_slot;
	ccc_pkg::score_t                sat_other;
	logic                           dbl;

	// "other" characters land on the total twice
	assign dbl       = (ctrl.cls.slot == ccc_pkg::SLOT_OTHER);
	assign add_other = dbl ? {ctrl.cls.weight, 1'b0} : {1'b0, ctrl.cls.weight};

	assign sum_slot  = {1'b0, row_in[ctrl.cls.slot]} + (ccc_pkg::SCORE_BITS+1)'(ctrl.cls.weight);
	assign sum_other = {1'b0, row_in[ccc_pkg::SLOT_OTHER]} + (ccc_pkg::SCORE_BITS+1)'(add_other);

	assign sat_slot  = sum_slot[ccc_pkg::SCORE_BITS]  ? '1 : sum_slot[ccc_pkg::SCORE_BITS-1:0];
	assign sat_other = sum_other[ccc_pkg::SCORE_BITS] ? '1 : sum_other[ccc_pkg::SCORE_BITS-1:0];

	assign wr_en = ctrl.valid && ctrl.in_range;

	always_comb begin
		wr_row = row_in;
		if (ctrl.is_read) begin
			wr_row = '0;
		end else if (ctrl.cls.hit) begin
			for (int i = 0; i < ccc_pkg::SLOT_COUNT - 1; i++) begin
				if (ctrl.cls.slot == ccc_pkg::CODE_W'(i)) begin
					wr_row[i] = sat_slot;
				end
			end
			wr_row[ccc_pkg::SLOT_OTHER] = sat_other;
		end
	end

	assign need = ccc_pkg::PROD_W'(cutoff) * ccc_pkg::PROD_W'(row_in[ccc_pkg::SLOT_OTHER]);

endmodule

### src/ccc_pick.sv
// Decision stage: first slot whose score times 100 reaches the cutoff product.
// Depends on ccc_pkg.
module ccc_pick (
	input  ccc_pkg::row_t                 row,
	input  logic [ccc_pkg::PROD_W-1:0]    need,
	input  logic                          in_range,
	output logic [ccc_pkg::CODE_W-1:0]    code
);

	logic [ccc_pkg::PROD_W-1:0] scaled [ccc_pkg::SLOT_COUNT];

	always_comb begin
		for (int i = 0; i < ccc_pkg::SLOT_COUNT; i++) begin
			scaled[i] = ccc_pkg::PROD_W'(row[i]) * ccc_pkg::PROD_W'(ccc_pkg::PERCENT_SCALE);
		end
	end

	always_comb begin
		code = ccc_pkg::CODE_NONE;
		// walk downward so the lowest matching slot wins
		for (int i = ccc_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
			if (scaled[i] >= need) begin
				code = ccc_pkg::CODE_W'(i);
			end
		end
		if (!in_range || row[ccc_pkg::SLOT_OTHER] == '0) begin
			code = ccc_pkg::CODE_NONE;
		end
	end

endmodule

### src/ccc_out_fifo.sv
// Small result buffer between the decision stage and the output channel.
// Depends on ccc_pkg.
module ccc_out_fifo (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  logic [ccc_pkg::CODE_W-1:0]      push_code,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [ccc_pkg::CODE_W-1:0]      out_code,
	output logic [ccc_pkg::OUT_CNT_W-1:0]   count
);

	logic [ccc_pkg::CODE_W-1:0]    mem_q [ccc_pkg::OUT_DEPTH];
	logic [ccc_pkg::OUT_PTR_W-1:0] wr_ptr_q;
	logic [ccc_pkg::OUT_PTR_W-1:0] rd_ptr_q;
	logic [ccc_pkg::OUT_CNT_W-1:0] cnt_q;
	logic                          pop;

	assign out_valid = (cnt_q != '0);
	assign out_code  = mem_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;
	assign count     = cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### src/column_consensus_caller.sv
// Top level of the column consensus caller.
// Depends on ccc_pkg, ccc_score_ram, ccc_update, ccc_pick and ccc_out_fifo.
//
// Usage
//   Input channel (in_valid/in_ready): one beat per item. req_type 0 adds the
//   weight of base_char to its slot and to the total of that column; req_type 1
//   reads the column's consensus and clears it. Accumulate beats give no result.
//   Output channel (out_valid/out_ready): one consensus_code beat per readout,
//   in the order the readouts were accepted.
//   Config channel (cfg_valid/cfg_ready): cutoff_percent, always ready; write it
//   only while no items are in flight.
// Timing
//   Each item passes through the modify stage: the column row is read from
//   the score RAM at acceptance, updated and written back the next cycle. A row
//   still being written is forwarded to an item on the same column right behind
//   it, so one item per cycle is sustained while in_ready stays high. A readout
//   result goes through the RAM read and cutoff multiply in the modify stage,
//   then the compare in the decision stage, into the output buffer.
//   Up to four readouts may be pending between the pipeline and the output buffer;
//   a stalled receiver holds in_ready low only once that room is used up.
// Reset
//   After reset the block sweeps the score RAM, one column per cycle, over all
//   MEM_DEPTH (4096) columns with in_ready low; cutoff resets to 100.
module column_consensus_caller (
	input  logic                            clk,
	input  logic                            arst_n,

	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            req_type,
	input  logic [ccc_pkg::COLUMN_W-1:0]    column,
	input  logic [ccc_pkg::CHAR_W-1:0]      base_char,

	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [ccc_pkg::CODE_W-1:0]      consensus_code,

	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ccc_pkg::CUTOFF_W-1:0]    cutoff_percent
);

	logic                              accept;
	logic [ccc_pkg::ADDR_W-1:0]        addr_in;
	logic                              in_range_in;

	// reset sweep
	logic                              clr_busy_q;
	logic [ccc_pkg::ADDR_W-1:0]        clr_addr_q;

	logic [ccc_pkg::CUTOFF_W-1:0]      cutoff_q;

	// modify stage
	ccc_pkg::s1_ctrl_t                 ctrl_s1;
	logic [ccc_pkg::ADDR_W-1:0]        addr_s1;
	logic                              fwd_hit_s1;
	ccc_pkg::row_t                     fwd_row_s1;
	ccc_pkg::row_t                     row_s1;

	// decision stage
	logic                              valid_s2;
	ccc_pkg::row_t                     row_s2;
	logic [ccc_pkg::PROD_W-1:0]        need_s2;
	logic                              in_range_s2;

	logic [ccc_pkg::ROW_W-1:0]         ram_rdata;
	logic                              ram_we;
	logic [ccc_pkg::ADDR_W-1:0]        ram_waddr;
	logic [ccc_pkg::ROW_W-1:0]         ram_wdata;

	logic                              upd_wr_en;
	ccc_pkg::row_t                     upd_row;
	logic [ccc_pkg::PROD_W-1:0]        upd_need;

	logic [ccc_pkg::CODE_W-1:0]        pick_code;
	logic [ccc_pkg::OUT_CNT_W-1:0]     fifo_count;
	logic [ccc_pkg::OUT_CNT_W:0]       pending;

	assign addr_in     = ccc_pkg::ADDR_W'(column);
	assign in_range_in = (32'(column) < 32'(ccc_pkg::COLUMNS));

	// readouts in the pipe plus results held in the buffer
	assign pending  = (ccc_pkg::OUT_CNT_W+1)'(fifo_count)
	                + (ccc_pkg::OUT_CNT_W+1)'(ctrl_s1.valid && ctrl_s1.is_read)
	                + (ccc_pkg::OUT_CNT_W+1)'(valid_s2);
	assign in_ready = !clr_busy_q && (pending < (ccc_pkg::OUT_CNT_W+1)'(ccc_pkg::OUT_DEPTH));
	assign accept   = in_valid && in_ready;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff_q <= ccc_pkg::CUTOFF_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cutoff_q <= cutoff_percent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == ccc_pkg::ADDR_W'(ccc_pkg::MEM_DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// sweep has the write port to itself; no items are in flight then
	assign ram_we    = clr_busy_q || upd_wr_en;
	assign ram_waddr = clr_busy_q ? clr_addr_q : addr_s1;
	assign ram_wdata = clr_busy_q ? '0 : upd_row;

	ccc_score_ram #(
		.DATA_W (ccc_pkg::ROW_W),
		.ADDR_W (ccc_pkg::ADDR_W),
		.DEPTH  (ccc_pkg::MEM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (addr_in),
		.rdata (ram_rdata)
	);

	// Item entering s1 on the column s1 is writing right now would read the old row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1    <= '0;
			fwd_hit_s1 <= 1'b0;
		end else begin
			ctrl_s1.valid    <= accept;
			ctrl_s1.is_read  <= req_type;
			ctrl_s1.in_range <= in_range_in;
			ctrl_s1.cls      <= ccc_pkg::classify(base_char);
			fwd_hit_s1       <= accept && upd_wr_en && (addr_s1 == addr_in);
		end
	end

	always_ff @(posedge clk) begin
		addr_s1    <= addr_in;
		fwd_row_s1 <= upd_row;
	end

	assign row_s1 = fwd_hit_s1 ? fwd_row_s1 : ccc_pkg::row_t'(ram_rdata);

	ccc_update u_update (
		.ctrl   (ctrl_s1),
		.row_in (row_s1),
		.cutoff (cutoff_q),
		.wr_en  (upd_wr_en),
		.wr_row (upd_row),
		.need   (upd_need)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= ctrl_s1.valid && ctrl_s1.is_read;
		end
	end

	always_ff @(posedge clk) begin
		row_s2      <= row_s1;
		need_s2     <= upd_need;
		in_range_s2 <= ctrl_s1.in_range;
	end

	ccc_pick u_pick (
		.row      (row_s2),
		.need     (need_s2),
		.in_range (in_range_s2),
		.code     (pick_code)
	);

	ccc_out_fifo u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s2),
		.push_code (pick_code),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_code  (consensus_code),
		.count     (fifo_count)
	);

`ifndef SYNTHESIS
	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending <= (ccc_pkg::OUT_CNT_W+1)'(ccc_pkg::OUT_DEPTH))
		else $error("readouts in flight exceed result buffer room");

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !(out_valid && out_ready) |->
			fifo_count < ccc_pkg::OUT_CNT_W'(ccc_pkg::OUT_DEPTH))
		else $error("result pushed into a full buffer");

	a_fwd_source: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_hit_s1 |-> ctrl_s1.valid && $past(upd_wr_en))
		else $error("forward taken without a write in the previous cycle");

	a_sweep_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !ctrl_s1.valid && !valid_s2 && !out_valid)
		else $error("item in flight during RAM sweep");
`endif

endmodule

### test/column_consensus_checker.sv
`timescale 1ns / 100ps
// Scoreboard for column_consensus_caller: keeps its own per-column slot scores,
// predicts the consensus_code of every readout beat and checks output beats in order.
// Depends on ccc_pkg for sizes, weights and the slot/code enum.
module column_consensus_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic                          req_type,
	input  logic [ccc_pkg::COLUMN_W-1:0]  column,
	input  logic [ccc_pkg::CHAR_W-1:0]    base_char,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [ccc_pkg::CODE_W-1:0]    consensus_code,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [ccc_pkg::CUTOFF_W-1:0]  cutoff_percent,
	output int unsigned                   pending,
	output int unsigned                   errors
);

	localparam int CHAR_COUNT = 29;
	localparam logic [8*CHAR_COUNT-1:0] READ_CHARS = "CTAG1234DVBHKLMNRY5678ctag*,-";

	ccc_pkg::score_t              tally [ccc_pkg::COLUMNS][ccc_pkg::SLOT_COUNT];
	logic [ccc_pkg::CUTOFF_W-1:0] cutoff_now;
	ccc_pkg::slot_t               calls_due [$];
	int unsigned                  miss_count;

	// Slot and weight of a read character; returns 0 when it adds nothing.
	function automatic logic weigh_char(input logic [ccc_pkg::CHAR_W-1:0] ch,
		output ccc_pkg::slot_t slot, output logic [ccc_pkg::WEIGHT_W-1:0] w);
		int i;
		slot = ccc_pkg::SLOT_C;
		w = '0;
		// NUL is not in the character list, it never matches
		if (ch == '0)
			return 1'b0;
		for (i = 0; i < CHAR_COUNT; i++) begin
			if (READ_CHARS[8*(CHAR_COUNT-1-i) +: 8] == ch) begin
				if (i < 16) begin
					slot = ccc_pkg::slot_t'(i % 4);
					w = (i >= 4 && i < 8) ? ccc_pkg::W_PART : ccc_pkg::W_FULL;
				end else if (i < 22 || i == CHAR_COUNT - 1) begin
					slot = ccc_pkg::SLOT_OTHER;
					w = ccc_pkg::W_LOW;
				end else if (i < 26) begin
					slot = ccc_pkg::slot_t'(i - 22);
					w = ccc_pkg::W_FULL;
				end else begin
					slot = ccc_pkg::SLOT_PAD;
					w = ccc_pkg::W_FULL;
				end
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic ccc_pkg::score_t sat_add(input ccc_pkg::score_t s,
		input logic [ccc_pkg::WEIGHT_W-1:0] w);
		logic [ccc_pkg::SCORE_BITS:0] sum;
		sum = {1'b0, s} + (ccc_pkg::SCORE_BITS+1)'(w);
		return sum[ccc_pkg::SCORE_BITS] ? {ccc_pkg::SCORE_BITS{1'b1}}
			: sum[ccc_pkg::SCORE_BITS-1:0];
	endfunction

	// First slot whose score reaches cutoff percent of the column total.
	function automatic ccc_pkg::slot_t call_column(input logic [ccc_pkg::COLUMN_W-1:0] col);
		logic [ccc_pkg::PROD_W-1:0] need;
		logic [ccc_pkg::PROD_W-1:0] share;
		int i;
		if (32'(col) >= ccc_pkg::COLUMNS || tally[col][ccc_pkg::SLOT_OTHER] == '0)
			return ccc_pkg::slot_t'(ccc_pkg::CODE_NONE);
		need = ccc_pkg::PROD_W'(cutoff_now) * ccc_pkg::PROD_W'(tally[col][ccc_pkg::SLOT_OTHER]);
		for (i = 0; i < ccc_pkg::SLOT_COUNT; i++) begin
			share = ccc_pkg::PROD_W'(tally[col][i]) * ccc_pkg::PROD_W'(ccc_pkg::PERCENT_SCALE);
			if (share >= need)
				return ccc_pkg::slot_t'(i);
		end
		return ccc_pkg::slot_t'(ccc_pkg::CODE_NONE);
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		ccc_pkg::slot_t               slot;
		ccc_pkg::slot_t               want;
		logic [ccc_pkg::WEIGHT_W-1:0] w;
		logic                         hit;
		int                           i;
		int                           j;
		if (!arst_n) begin
			for (i = 0; i < ccc_pkg::COLUMNS; i++)
				for (j = 0; j < ccc_pkg::SLOT_COUNT; j++)
					tally[i][j] = '0;
			cutoff_now = ccc_pkg::CUTOFF_RESET;
			calls_due.delete();
			miss_count = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (calls_due.size() == 0) begin
					miss_count++;
					if (miss_count <= 10)
						$display("%0t: consensus_code %0d with no readout outstanding",
							$time, consensus_code);
				end else begin
					want = calls_due.pop_front();
					if (consensus_code !== want) begin
						miss_count++;
						if (miss_count <= 10)
							$display("%0t: consensus_code expected %0d got %0d",
								$time, want, consensus_code);
					end
				end
			end
			if (cfg_valid && cfg_ready)
				cutoff_now = cutoff_percent;
			if (in_valid && in_ready) begin
				if (req_type) begin
					calls_due.push_back(call_column(column));
					if (32'(column) < ccc_pkg::COLUMNS)
						for (j = 0; j < ccc_pkg::SLOT_COUNT; j++)
							tally[column][j] = '0;
				end else if (32'(column) < ccc_pkg::COLUMNS) begin
					hit = weigh_char(base_char, slot, w);
					if (hit) begin
						tally[column][slot] = sat_add(tally[column][slot], w);
						tally[column][ccc_pkg::SLOT_OTHER] =
							sat_add(tally[column][ccc_pkg::SLOT_OTHER], w);
					end
				end
			end
		end
		pending <= calls_due.size();
		errors <= miss_count;
	end

endmodule

### test/column_consensus_caller_tb.sv
`timescale 1ns / 100ps
// Testbench top for column_consensus_caller: drives accumulate/readout beats and
// cutoff writes with random gaps and output stalls, then gives the verdict.
// Depends on ccc_pkg, the RTL in src/ and column_consensus_checker.
module column_consensus_caller_tb;

	localparam logic REQ_ADD  = 1'b0;
	localparam logic REQ_READ = 1'b1;

	// Every character that scores, in list order; grouped by slot as C T A G.
	localparam int CHAR_COUNT = 29;
	localparam logic [8*CHAR_COUNT-1:0] READ_CHARS = "CTAG1234DVBHKLMNRY5678ctag*,-";

	localparam int RAND_PER_PHASE = 150;
	localparam int PHASES         = 8;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_COMB
	} rx_mode_t;

	logic                         clk            = 1'b0;
	logic                         arst_n         = 1'b0;
	logic                         in_valid       = 1'b0;
	logic                         in_ready;
	logic                         req_type       = REQ_ADD;
	logic [ccc_pkg::COLUMN_W-1:0] column         = '0;
	logic [ccc_pkg::CHAR_W-1:0]   base_char      = '0;
	logic                         out_valid;
	logic                         out_ready      = 1'b0;
	logic [ccc_pkg::CODE_W-1:0]   consensus_code;
	logic                         cfg_valid      = 1'b0;
	logic                         cfg_ready;
	logic [ccc_pkg::CUTOFF_W-1:0] cutoff_percent = ccc_pkg::CUTOFF_RESET;

	int unsigned pending;
	int unsigned errors;

	// sender burst state: beats left before the next gap
	int burst_left = 0;

	// receiver stall pattern
	rx_mode_t rx_mode = RX_OPEN;
	int       rx_hold = 0;
	logic [2:0] rx_tick = '0;

	column_consensus_caller uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.req_type       (req_type),
		.column         (column),
		.base_char      (base_char),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.consensus_code (consensus_code),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cutoff_percent (cutoff_percent)
	);

	column_consensus_checker u_score (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.req_type       (req_type),
		.column         (column),
		.base_char      (base_char),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.consensus_code (consensus_code),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cutoff_percent (cutoff_percent),
		.pending        (pending),
		.errors         (errors)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Receiver: holds one stall mode for a random stretch, then picks another.
	// Open mode gives long runs with no backpressure at all.
	always @(posedge clk) begin
		if (rx_hold == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
			rx_hold <= $urandom_range(16, 160);
		end else begin
			rx_hold <= rx_hold - 1;
		end
		rx_tick <= rx_tick + 3'd1;
		case (rx_mode)
			RX_OPEN: begin
				out_ready <= 1'b1;
			end
			RX_COIN: begin
				out_ready <= 1'($urandom_range(0, 1));
			end
			RX_SPARSE: begin
				out_ready <= ($urandom_range(0, 3) == 0);
			end
			default: begin
				// ready while rx_tick is below five, in a fixed comb
				out_ready <= (rx_tick < 3'd5);
			end
		endcase
	end

	// One input beat. Called at a clock edge; returns at the edge that accepted it.
	// Beats come in bursts; between bursts valid drops for a random gap, and a
	// quarter of the bursts run straight on from the previous one.
	task automatic push_beat(input logic kind, input logic [ccc_pkg::COLUMN_W-1:0] col,
		input logic [ccc_pkg::CHAR_W-1:0] ch);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid  <= 1'b1;
		req_type  <= kind;
		column    <= col;
		base_char <= ch;
		do @(posedge clk); while (!in_ready);
	endtask

	// Stop sending and wait until every readout has come back. Accumulates give
	// no result, so a further wait lets the last write-back land before a
	// cutoff write.
	task automatic settle();
		in_valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_cutoff(input logic [ccc_pkg::CUTOFF_W-1:0] pct);
		cfg_valid      <= 1'b1;
		cutoff_percent <= pct;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Read character biased toward one base: just over half the time a spelling
	// of the leading base, else any scoring character, else a random byte
	// (mostly characters that add nothing).
	function automatic logic [ccc_pkg::CHAR_W-1:0] pick_char(input logic [1:0] lead);
		int r;
		int idx;
		r = $urandom_range(0, 99);
		if (r < 15)
			return ccc_pkg::CHAR_W'($urandom_range(0, 255));
		if (r < 45) begin
			idx = $urandom_range(0, CHAR_COUNT - 1);
		end else begin
			idx = $urandom_range(0, 4);
			// upper case, digit, two ambiguity letters, then lower case
			idx = (idx == 4) ? 22 + lead : lead + 4 * idx;
		end
		return READ_CHARS[8*(CHAR_COUNT-1-idx) +: 8];
	endfunction

	// Random traffic over four live columns, each with its own leading base.
	// A readout closes a column and a fresh one takes its place; now and then a
	// random column is read, which is almost always empty.
	task automatic run_mix(input int n);
		logic [ccc_pkg::COLUMN_W-1:0] live_col [4];
		logic [1:0]                   lead [4];
		int                           k;
		int                           i;
		int                           r;
		for (k = 0; k < 4; k++) begin
			live_col[k] = ccc_pkg::COLUMN_W'($urandom_range(0, (1 << ccc_pkg::COLUMN_W) - 1));
			lead[k] = 2'($urandom_range(0, 3));
		end
		k = 0;
		for (i = 0; i < n; i++) begin
			// otherwise stay on the last column: back-to-back beats on one
			// column go through the write-back forwarding path
			if ($urandom_range(0, 99) < 60)
				k = $urandom_range(0, 3);
			r = $urandom_range(0, 19);
			if (r < 2) begin
				push_beat(REQ_READ, live_col[k], ccc_pkg::CHAR_W'($urandom_range(0, 255)));
				live_col[k] = ccc_pkg::COLUMN_W'($urandom_range(0,
					(1 << ccc_pkg::COLUMN_W) - 1));
				lead[k] = 2'($urandom_range(0, 3));
			end else if (r == 2) begin
				push_beat(REQ_READ,
					ccc_pkg::COLUMN_W'($urandom_range(0, (1 << ccc_pkg::COLUMN_W) - 1)),
					ccc_pkg::CHAR_W'($urandom_range(0, 255)));
			end else begin
				push_beat(REQ_ADD, live_col[k], pick_char(lead[k]));
			end
		end
	endtask

	initial begin : stim
		logic [ccc_pkg::CUTOFF_W-1:0] cut_steps [PHASES];
		int p;
		// cutoff per random phase: both extremes, the usual values, and just
		// over 100 where nothing but no-consensus can come out
		cut_steps = '{7'd0, 7'd127, 7'd50, 7'd100, 7'd1, 7'd101, 7'd75, 7'd0};
		cut_steps[PHASES-1] = ccc_pkg::CUTOFF_W'($urandom_range(0, 127));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed beats at the reset cutoff of 100. in_ready stays low through
		// the RAM clearing sweep; push_beat just waits it out.
		// empty column: zero total gives no consensus
		push_beat(REQ_READ, 12'd0, 8'hFF);
		// single base wins outright
		push_beat(REQ_ADD, 12'd0, "C");
		push_beat(REQ_READ, 12'd0, 8'h00);
		// full and partial weights on one slot, top column
		push_beat(REQ_ADD, 12'd4095, "T");
		push_beat(REQ_ADD, 12'd4095, "2");
		push_beat(REQ_ADD, 12'd4095, "t");
		push_beat(REQ_READ, 12'd4095, "C");
		// both pad characters
		push_beat(REQ_ADD, 12'd1, "*");
		push_beat(REQ_ADD, 12'd1, ",");
		push_beat(REQ_READ, 12'd1, "G");
		// an "other" character counts twice into the total
		push_beat(REQ_ADD, 12'd2, "R");
		push_beat(REQ_READ, 12'd2, "A");
		// NUL, a high byte and an unlisted character add nothing
		push_beat(REQ_ADD, 12'd3, 8'h00);
		push_beat(REQ_ADD, 12'd3, 8'hFF);
		push_beat(REQ_ADD, 12'd3, "@");
		push_beat(REQ_READ, 12'd3, "T");
		// split column: no slot reaches the full total
		push_beat(REQ_ADD, 12'd5, "A");
		push_beat(REQ_ADD, 12'd5, "3");
		push_beat(REQ_ADD, 12'd5, "G");
		push_beat(REQ_READ, 12'd5, "-");

		// Random phases, each under its own cutoff, written with the pipe empty.
		for (p = 0; p < PHASES; p++) begin
			settle();
			set_cutoff(cut_steps[p]);
			run_mix(RAND_PER_PHASE);
		end

		settle();
		repeat (16) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("[column_consensus_caller] OK");
		else
			$display("[column_consensus_caller] ERROR");
		$finish;
	end

	// Watchdog: reports an error and stops the run if it has not finished in time.
	initial begin
		#6_000_000;
		$display("[column_consensus_caller] ERROR");
		$finish;
	end

endmodule

### files.f
src/ccc_pkg.sv
src/ccc_score_ram.sv
src/ccc_update.sv
src/ccc_pick.sv
src/ccc_out_fifo.sv
src/column_consensus_caller.sv
test/column_consensus_checker.sv
test/column_consensus_caller_tb.sv
